### sv/cobsrx_pkg.sv
// Shared types and constants for the COBS frame receiver.
`default_nettype none

package cobsrx_pkg;

    localparam int RAW_MAX_DEF     = 64;
    localparam int FRAME_BYTES_DEF = 4;

    localparam logic [7:0] DELIM_BYTE = 8'h00;
    localparam logic [7:0] CODE_MAX   = 8'hFF;
    localparam logic [6:0] DEC_SAT    = 7'd127;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_LEN_MISMATCH = 2'd1,
        ST_BROKEN_BLOCK = 2'd2
    } t_frame_status;

    typedef struct packed {
        t_frame_status      status;
        logic [6:0]         length;
        logic signed [31:0] value;
    } t_cobsrx_result;

endpackage

`default_nettype wire

### sv/cobs_frame_receiver.sv
// Top level of the COBS frame receiver: input register, decoder, result register.
`default_nettype none

// Decodes a COBS byte stream on the fly, one received byte a word on the slave side.
// A zero byte closes a non-empty frame and produces one result word carrying the status,
// the decoded length and the last accepted 32-bit payload. The block takes one byte per
// clock cycle when the result side is not stalled; a byte is decoded from the input register
// and a frame result is registered from that decode in the result register, so the result
// word is offered from the result register once its delimiter has been decoded.
// The throughput is set by the decode state update between the input register
// and the result register. The input stalls only when a delimiter would produce a result
// while the previous result is still waiting. The byte past RAW_MAX within one frame is
// dropped and decoding restarts with the next byte as a code byte.
module cobs_frame_receiver
    import cobsrx_pkg::*;
#(
    parameter int RAW_MAX     = RAW_MAX_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // [1:0] frame_status, [8:2] decoded_length,
                                             // [40:9] frame_value, [47:41] zero
);

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_out_valid;
    t_cobsrx_result r_out;

    logic           w_fire;
    logic           w_in_take;
    t_cobsrx_result w_result;

    cobsrx_core #(
        .RAW_MAX     (RAW_MAX),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (w_in_take),
        .i_byte        (r_in_byte),
        .o_result_fire (w_fire),
        .o_result      (w_result)
    );

    // Hold the byte when it would produce a result and the result register is stalled.
    assign w_in_take     = r_in_valid && (!w_fire || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_take && w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take && w_fire) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.value, r_out.length, r_out.status};

    a_broken_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_BROKEN_BLOCK) |-> r_out.length == 7'd0)
        else $error("broken block result with non-zero length");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_OK) |-> r_out.length == 7'(FRAME_BYTES))
        else $error("ok result with wrong length");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && w_fire && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire

### sv/cobsrx_core.sv
// COBS decode state and per-byte next-state and frame result logic.
`default_nettype none

module cobsrx_core
    import cobsrx_pkg::*;
#(
    parameter int RAW_MAX     = RAW_MAX_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_byte_valid,
    input  wire logic [7:0]     i_byte,
    output logic                o_result_fire,
    output t_cobsrx_result      o_result
);

    localparam int RAW_W = $clog2(RAW_MAX + 1);

    logic [RAW_W-1:0] r_raw_count, n_raw_count;
    logic [7:0]       r_block_left, n_block_left;
    logic             r_zero_pending, n_zero_pending;
    logic [6:0]       r_dec_count, n_dec_count;
    logic [7:0]       r_payload [FRAME_BYTES];
    logic [7:0]       n_payload [FRAME_BYTES];
    logic [31:0]      r_held, n_held;

    logic             w_emit_en;
    logic [7:0]       w_emit_byte;
    logic [31:0]      w_assembled;
    t_frame_status    w_status;

    // Gather the first decoded bytes little-endian; bytes past the frame size read zero.
    for (genvar g = 0; g < 4; g++) begin : g_asm
        if (g < FRAME_BYTES) begin : g_byte
            assign w_assembled[8*g +: 8] = r_payload[g];
        end else begin : g_zero
            assign w_assembled[8*g +: 8] = 8'h00;
        end
    end

    always_comb begin
        if (r_block_left != 8'd0) begin
            w_status = ST_BROKEN_BLOCK;
        end else if (r_dec_count == 7'(FRAME_BYTES)) begin
            w_status = ST_OK;
        end else begin
            w_status = ST_LEN_MISMATCH;
        end
    end

    assign o_result_fire   = (i_byte == DELIM_BYTE) && (r_raw_count != '0);
    assign o_result.status = w_status;
    assign o_result.length = (w_status == ST_BROKEN_BLOCK) ? 7'd0 : r_dec_count;
    assign o_result.value  = (w_status == ST_OK) ? w_assembled : r_held;

    always_comb begin
        n_raw_count    = r_raw_count;
        n_block_left   = r_block_left;
        n_zero_pending = r_zero_pending;
        n_dec_count    = r_dec_count;
        n_held         = r_held;
        n_payload      = r_payload;
        w_emit_en      = 1'b0;
        w_emit_byte    = i_byte;

        if (i_byte_valid) begin
            if (i_byte != DELIM_BYTE) begin
                if (r_raw_count >= RAW_W'(RAW_MAX)) begin
                    // overflow: drop the byte and restart the frame
                    n_raw_count    = '0;
                    n_block_left   = 8'd0;
                    n_zero_pending = 1'b0;
                    n_dec_count    = 7'd0;
                end else begin
                    n_raw_count = r_raw_count + 1'b1;
                    if (r_block_left == 8'd0) begin
                        w_emit_en      = r_zero_pending;
                        w_emit_byte    = 8'h00;
                        n_block_left   = i_byte - 8'd1;
                        n_zero_pending = (i_byte != CODE_MAX);
                    end else begin
                        w_emit_en    = 1'b1;
                        n_block_left = r_block_left - 8'd1;
                    end
                end
            end else if (r_raw_count != '0) begin
                if (w_status == ST_OK) begin
                    n_held = w_assembled;
                end
                n_raw_count    = '0;
                n_block_left   = 8'd0;
                n_zero_pending = 1'b0;
                n_dec_count    = 7'd0;
            end
        end

        if (w_emit_en) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                if (r_dec_count == 7'(i)) begin
                    n_payload[i] = w_emit_byte;
                end
            end
            if (r_dec_count != DEC_SAT) begin
                n_dec_count = r_dec_count + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_count    <= '0;
            r_block_left   <= 8'd0;
            r_zero_pending <= 1'b0;
            r_dec_count    <= 7'd0;
            r_held         <= 32'd0;
        end else begin
            r_raw_count    <= n_raw_count;
            r_block_left   <= n_block_left;
            r_zero_pending <= n_zero_pending;
            r_dec_count    <= n_dec_count;
            r_held         <= n_held;
        end
    end

    // Payload bytes are only read once all of them are written in the same frame.
    always_ff @(posedge i_clk) begin
        r_payload <= n_payload;
    end

endmodule

`default_nettype wire

### sim/cobs_frame_receiver_tb.sv
// Testbench for the COBS frame receiver: directed and random COBS frames against a self-checking predictor.
`timescale 1ns / 100ps

module cobs_frame_receiver_tb;
    import cobsrx_pkg::*;

    typedef logic [7:0] t_byte_q [$];

    typedef struct {
        t_frame_status status;
        logic [6:0]    length;
        logic [31:0]   value;
    } t_frame_result;

    // Predicts frame results from accepted bytes and checks result words in order.
    class frame_scoreboard;
        int                raw_count;
        int                block_left;
        bit                zero_pending;
        int                dec_count;
        logic [7:0]        payload [FRAME_BYTES_DEF];
        logic [31:0]       held_value;
        t_frame_result     expected_frames [$];
        int                errors;

        function new();
            restart();
            foreach (payload[i])
                payload[i] = 8'h00;
            held_value = '0;
            errors     = 0;
        endfunction

        function void restart();
            raw_count    = 0;
            block_left   = 0;
            zero_pending = 1'b0;
            dec_count    = 0;
        endfunction

        function void put_decoded(logic [7:0] b);
            if (dec_count < FRAME_BYTES_DEF)
                payload[dec_count] = b;
            if (dec_count < int'(DEC_SAT))
                dec_count++;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: mismatch: %s", $realtime, msg);
        endfunction

        function void note_byte(logic [7:0] b);
            t_frame_result r;
            if (b != DELIM_BYTE) begin
                if (raw_count >= RAW_MAX_DEF) begin
                    restart();
                    return;
                end
                raw_count++;
                if (block_left == 0) begin
                    if (zero_pending)
                        put_decoded(8'h00);
                    block_left   = int'(b) - 1;
                    zero_pending = (b != CODE_MAX);
                end else begin
                    put_decoded(b);
                    block_left--;
                end
                return;
            end
            // drop empty frames silently
            if (raw_count == 0)
                return;
            if (block_left != 0) begin
                r.status = ST_BROKEN_BLOCK;
                r.length = '0;
            end else if (dec_count == FRAME_BYTES_DEF) begin
                r.status   = ST_OK;
                r.length   = 7'(dec_count);
                held_value = '0;
                for (int i = 0; i < 4 && i < FRAME_BYTES_DEF; i++)
                    held_value[8*i +: 8] = payload[i];
            end else begin
                r.status = ST_LEN_MISMATCH;
                r.length = 7'(dec_count);
            end
            r.value = held_value;
            expected_frames.push_back(r);
            restart();
        endfunction

        function void check_result(logic [47:0] d);
            t_frame_result exp_r;
            t_frame_status got_status;
            logic [6:0]    got_length;
            logic [31:0]   got_value;
            got_status = t_frame_status'(d[1:0]);
            got_length = d[8:2];
            got_value  = d[40:9];
            if (expected_frames.size() == 0) begin
                report($sformatf("unexpected result word %h", d));
                return;
            end
            exp_r = expected_frames.pop_front();
            if (got_status != exp_r.status)
                report($sformatf("status exp %0d got %0d", exp_r.status, got_status));
            if (got_length != exp_r.length)
                report($sformatf("length exp %0d got %0d", exp_r.length, got_length));
            if (got_value != exp_r.value)
                report($sformatf("value exp %h got %h", exp_r.value, got_value));
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    frame_scoreboard sb = new();
    int              bytes_seen;
    int              bytes_sent;
    bit              steady;

    cobs_frame_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_byte(s_axis_tdata);
                bytes_seen++;
            end
        end
    end

    // Mostly short gaps, now and then a long one; none while steady is set.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_byte_q frame);
        foreach (frame[i])
            send_byte(frame[i]);
    endtask

    task automatic cobs_encode(input t_byte_q payload, output t_byte_q enc);
        int code_idx;
        int code;
        enc      = {};
        code_idx = 0;
        code     = 1;
        enc.push_back(8'h00);
        foreach (payload[i]) begin
            if (payload[i] == 8'h00) begin
                enc[code_idx] = 8'(code);
                code_idx      = enc.size();
                enc.push_back(8'h00);
                code = 1;
            end else begin
                enc.push_back(payload[i]);
                code++;
                if (code == 255) begin
                    enc[code_idx] = 8'(code);
                    code_idx      = enc.size();
                    enc.push_back(8'h00);
                    code = 1;
                end
            end
        end
        enc[code_idx] = 8'(code);
    endtask

    task automatic send_random_frame();
        t_byte_q payload;
        t_byte_q enc;
        int      kind;
        int      n;
        int      code;
        kind = $urandom_range(0, 99);
        payload = {};
        enc     = {};
        if (kind < 70) begin
            // well-formed frame, mostly of the expected payload size
            n = ($urandom_range(0, 4) != 0) ? FRAME_BYTES_DEF : $urandom_range(0, 9);
            repeat (n)
                payload.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom()));
            cobs_encode(payload, enc);
        end else if (kind < 80) begin
            // block cut short by the delimiter
            code = $urandom_range(2, 255);
            enc.push_back(8'(code));
            repeat ($urandom_range(0, (code - 2 < 6) ? code - 2 : 6))
                enc.push_back(8'($urandom_range(1, 255)));
        end else if (kind < 88) begin
            repeat ($urandom_range(1, 12))
                enc.push_back(8'($urandom()));
        end else if (kind < 94) begin
            // fill the raw buffer up to or past its limit
            n = ($urandom_range(0, 2) == 0) ? RAW_MAX_DEF : $urandom_range(60, 80);
            repeat (n)
                enc.push_back(($urandom_range(0, 1) != 0) ? 8'h01 : 8'($urandom_range(1, 255)));
        end else begin
            enc.push_back(DELIM_BYTE);
        end
        enc.push_back(DELIM_BYTE);
        send_frame(enc);
    endtask

    // Result side: random ready pattern plus one long hold-off mid run.
    initial begin
        bit held;
        int run;
        int gap;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && bytes_seen >= 300) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            run = $urandom_range(1, 30);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        int frames;
        int guard;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        bytes_seen    = 0;
        bytes_sent    = 0;
        steady        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame('{8'h00});
        send_frame('{8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00});
        send_frame('{8'h02, 8'h80, 8'h03, 8'hFF, 8'hFE, 8'h00});
        send_frame('{8'h03, 8'h11, 8'h00});
        send_frame('{8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00});
        send_frame('{8'h02, 8'h7F, 8'h00});
        send_frame('{8'hFF, 8'h55, 8'h00});

        frames = 0;
        while (bytes_sent < 900) begin
            steady = (frames >= 40 && frames < 60);
            send_random_frame();
            frames++;
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/cobsrx_pkg.sv
sv/cobsrx_core.sv
sv/cobs_frame_receiver.sv
sim/cobs_frame_receiver_tb.sv
